@@ rtl/core/aba_pkg.sv @@
// Shared types and constants for the aligned bump allocator.
package aba_pkg;

   localparam int unsigned COUNT_W  = 25;
   localparam int unsigned SIZE_W   = 25;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned USED_W   = 25;
   localparam int unsigned DIV_W    = SIZE_W + 1;
   localparam int unsigned PROD_W   = COUNT_W + SIZE_W;
   localparam int unsigned DIV_STEPS = ADDR_W;
   localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

   localparam logic [USED_W-1:0] POOL_BYTES = USED_W'(16777216);
   localparam int unsigned LINE_BYTES = 64;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_PAD  = 2'd1,
      STAT_NO_ROOM = 2'd2,
      STAT_HALTED  = 2'd3
   } status_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [DIV_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

@@ rtl/core/aba_if.sv @@
// Request, response and register-write channel interfaces.
interface aba_req_if;
   logic                         valid;
   logic                         ready;
   logic [aba_pkg::COUNT_W-1:0]  elem_count;
   logic [aba_pkg::SIZE_W-1:0]   elem_size;

   modport source (output valid, elem_count, elem_size, input ready);
   modport sink (input valid, elem_count, elem_size, output ready);
endinterface

interface aba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [aba_pkg::ADDR_W-1:0]   alloc_addr;
   logic [aba_pkg::USED_W-1:0]   pad_bytes;
   logic [aba_pkg::USED_W-1:0]   used_after;

   modport source (output valid, status, alloc_addr, pad_bytes, used_after, input ready);
   modport sink (input valid, status, alloc_addr, pad_bytes, used_after, output ready);
endinterface

interface aba_csr_if;
   logic                         valid;
   logic                         ready;
   logic [aba_pkg::ADDR_W-1:0]   region_base;

   modport source (output valid, region_base, input ready);
   modport sink (input valid, region_base, output ready);
endinterface

@@ rtl/core/aba_divider.sv @@
// Iterative restoring remainder unit, one quotient bit per cycle.
module aba_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  aba_pkg::div_req_type  div_req,
   output aba_pkg::div_rsp_type  div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [aba_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [aba_pkg::ADDR_W-1:0]   dvd_ff, dvd_in;
   logic [aba_pkg::DIV_W-1:0]    dsr_ff, dsr_in;
   logic [aba_pkg::DIV_W-1:0]    rem_ff, rem_in;
   logic [aba_pkg::DIV_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[aba_pkg::ADDR_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = aba_pkg::DIV_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[aba_pkg::DIV_W-1:0];
         end
         dvd_in = {dvd_ff[aba_pkg::ADDR_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == aba_pkg::STEP_W'(aba_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (busy_ff && !done_ff))
      else $error("divider did not start");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while busy");

endmodule

@@ rtl/core/aligned_bump_allocator.sv @@
// Aligned bump allocator top level: sequencer, pool state and response register.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     elem_count, elem_size
//   rsp      out  valid/ready     status, alloc_addr, pad_bytes, used_after
//   csr      in   valid/ready     region_base
//
// A request passes through ST_DIV (the 32-step remainder loop), ST_PAD, ST_FIT
// and ST_OUT; a request after a halt goes from ST_IDLE straight to ST_OUT.
// req ready is high only while the sequencer is idle; the response register
// lets the next request in while a response waits on rsp ready.
// Synchronous reset clears pool usage, the halted flag and region_base.
module aligned_bump_allocator (
   input  logic        clock,
   input  logic        reset,
   aba_req_if.sink     req_port,
   aba_rsp_if.source   rsp_port,
   aba_csr_if.sink     csr_port
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PAD,
      ST_FIT,
      ST_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic                         halted_ff, halted_in;
   logic [aba_pkg::USED_W-1:0]   used_ff, used_in;
   logic [aba_pkg::ADDR_W-1:0]   base_ff, base_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [aba_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [aba_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [aba_pkg::DIV_W-1:0]    div_ff, div_in;
   logic [aba_pkg::ADDR_W-1:0]   cur_ff, cur_in;
   logic [aba_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [aba_pkg::DIV_W-1:0]    pad_ff, pad_in;
   logic [aba_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   aba_pkg::status_type          status_ff, status_in;

   aba_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [aba_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [aba_pkg::USED_W-1:0]   rsp_pad_ff, rsp_pad_in;
   logic [aba_pkg::USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic                         req_fire;
   logic [aba_pkg::DIV_W-1:0]    req_div;
   logic [aba_pkg::USED_W-1:0]   room;
   aba_pkg::div_req_type         div_req;
   aba_pkg::div_rsp_type         div_rsp;

   assign req_port.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_port.ready = !reset;
   assign req_fire       = req_port.valid && req_port.ready;

   // divisor = size rounded down to a line, plus one line
   assign req_div = aba_pkg::DIV_W'(req_port.elem_size)
                  + aba_pkg::DIV_W'(aba_pkg::LINE_BYTES)
                  - aba_pkg::DIV_W'(req_port.elem_size % aba_pkg::LINE_BYTES);

   assign div_req.start    = req_fire && !halted_ff;
   assign div_req.dividend = base_ff + aba_pkg::ADDR_W'(used_ff);
   assign div_req.divisor  = req_div;

   aba_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign room = aba_pkg::POOL_BYTES - used_ff;

   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      used_in       = used_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      div_in        = div_ff;
      cur_in        = cur_ff;
      prod_in       = prod_ff;
      pad_in        = pad_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pad_in    = rsp_pad_ff;
      rsp_used_in   = rsp_used_ff;

      if (csr_port.valid && csr_port.ready) begin
         base_in = csr_port.region_base;
      end
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in  = req_port.elem_count;
               size_in   = req_port.elem_size;
               div_in    = req_div;
               cur_in    = div_req.dividend;
               addr_in   = '0;
               pad_in    = '0;
               status_in = aba_pkg::STAT_OK;
               if (halted_ff) begin
                  status_in = aba_pkg::STAT_HALTED;
                  state_in  = ST_OUT;
               end else begin
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            prod_in = count_ff * size_ff;
            if (div_rsp.done) begin
               pad_in   = (div_rsp.remainder == '0) ? '0 : div_ff - div_rsp.remainder;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (pad_ff > {1'b0, room}) begin
               status_in = aba_pkg::STAT_NO_PAD;
               halted_in = 1'b1;
               state_in  = ST_OUT;
            end else begin
               used_in  = used_ff + pad_ff[aba_pkg::USED_W-1:0];
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (prod_ff > aba_pkg::PROD_W'(room)) begin
               status_in = aba_pkg::STAT_NO_ROOM;
               halted_in = 1'b1;
            end else begin
               used_in = used_ff + prod_ff[aba_pkg::USED_W-1:0];
               addr_in = cur_ff + aba_pkg::ADDR_W'(pad_ff);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = addr_ff;
               rsp_pad_in    = pad_ff[aba_pkg::USED_W-1:0];
               rsp_used_in   = used_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      size_ff       <= size_in;
      div_ff        <= div_in;
      cur_ff        <= cur_in;
      prod_ff       <= prod_in;
      pad_ff        <= pad_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pad_ff    <= rsp_pad_in;
      rsp_used_ff   <= rsp_used_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b0;
         used_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.status     = rsp_status_ff;
   assign rsp_port.alloc_addr = rsp_addr_ff;
   assign rsp_port.pad_bytes  = rsp_pad_ff;
   assign rsp_port.used_after = rsp_used_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared");

   a_used_in_pool: assert property (@(posedge clock) disable iff (reset)
      used_ff <= aba_pkg::POOL_BYTES)
      else $error("pool usage beyond pool size");

   a_halted_fast: assert property (@(posedge clock) disable iff (reset)
      (req_fire && halted_ff) |=> (state_ff == ST_OUT && status_ff == aba_pkg::STAT_HALTED))
      else $error("halted request not answered at once");

   a_idle_used_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(used_ff))
      else $error("pool usage changed while idle");

endmodule
